FILE: rtl/core/tsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and fixed field widths for the timestamp sort/dedup unit.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int KEY_W = 64;
  localparam int REF_W = 6;
  localparam int CNT_W = 7;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [REF_W-1:0] ref_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_DEC,
    S_EMIT,
    S_ORD,
    S_ORDD
  } state_t;

endpackage

FILE: rtl/core/tsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module tsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/core/timestamp_sort_dedup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_sort_dedup_unit
// Collects a block of rows, then emits them in arrival order or sorted by
// signed key with duplicate keys removed (earliest arrival kept).
// ----------------------------------------------------------------------------
// Loading accepts one row request per cycle. Once the last row is in, an ordered
// block emits its rows in turn, each read in S_ORD, registered in S_ORDD and held
// in S_EMIT until taken. An unordered block is sorted by repeated passes over the
// row memory: each pass reads all n stored rows, one per cycle through the single
// read port, and finds the smallest key above the one emitted before. No row
// request is taken during emission; a new block starts after the final row has
// been taken.
module timestamp_sort_dedup_unit #(
  parameter int MAX_ROWS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tsd_pkg::key_t in_row_key,
  input  tsd_pkg::ref_t in_row_ref,
  input  logic          in_already_ordered,
  input  logic          in_last_row,
  output logic          out_valid,
  input  logic          out_stall,
  output tsd_pkg::key_t out_key,
  output tsd_pkg::ref_t out_ref,
  output logic          out_last,
  output tsd_pkg::cnt_t out_kept_count,
  output logic          out_overflowed
);
  import tsd_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int DW = KEY_W + REF_W;

  state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, sa_r, kept_r;
  logic          ovf_r, ord_r;
  logic          pv_r, found_r, have_r;
  logic [AW-1:0] pidx_r;
  key_t          best_key_r, cand_key_r, rd_key;
  ref_t          best_ref_r, cand_ref_r, rd_ref;
  logic          out_valid_r, out_last_r, out_ovf_r;
  key_t          out_key_r;
  ref_t          out_ref_r;
  cnt_t          out_kept_r;

  logic          in_acc, wr_en, scan_end, better;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata_r;

  assign in_acc = in_valid && !in_stall;
  assign wr_en  = in_acc && (cnt_r < CW'(MAX_ROWS));
  assign rd_key = rdata_r[DW-1:REF_W];
  assign rd_ref = rdata_r[REF_W-1:0];

  tsd_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (cnt_r[AW-1:0]),
    .wdata   ({in_row_key, in_row_ref}),
    .raddr   (raddr),
    .rdata_r (rdata_r)
  );

  // candidate test: above the previous key, below the best so far
  assign better = (!have_r || ($signed(rd_key) > $signed(cand_key_r))) &&
                  (!found_r || ($signed(rd_key) < $signed(best_key_r)));
  assign scan_end = pv_r && ((CW'(pidx_r) + CW'(1)) == cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_acc && in_last_row) begin
          state_nxt = in_already_ordered ? S_ORD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) state_nxt = S_DEC;
      end
      S_DEC:  state_nxt = have_r ? S_EMIT : S_SCAN;
      S_EMIT: begin
        if (!out_stall) begin
          if (out_last_r)  state_nxt = S_LOAD;
          else if (ord_r)  state_nxt = S_ORD;
          else             state_nxt = S_SCAN;
        end
      end
      S_ORD:  state_nxt = S_ORDD;
      S_ORDD: state_nxt = S_EMIT;
      default: state_nxt = S_LOAD;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall = (state_r != S_LOAD);
    raddr    = sa_r[AW-1:0];
  end

  // state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      ord_r       <= 1'b0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      have_r      <= 1'b0;
      sa_r        <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (wr_en) cnt_r <= cnt_r + CW'(1);
            else       ovf_r <= 1'b1;
            ord_r   <= in_already_ordered;
            sa_r    <= '0;
            kept_r  <= '0;
            have_r  <= 1'b0;
            found_r <= 1'b0;
            pv_r    <= 1'b0;
          end
        end
        S_SCAN: begin
          // issue reads, then track the best candidate
          if (sa_r < cnt_r) begin
            pv_r <= 1'b1;
            sa_r <= sa_r + CW'(1);
          end else begin
            pv_r <= 1'b0;
          end
          if (pv_r && better) found_r <= 1'b1;
        end
        S_DEC: begin
          sa_r    <= '0;
          found_r <= 1'b0;
          pv_r    <= 1'b0;
          if (!have_r) begin
            have_r <= 1'b1;
          end else begin
            out_valid_r <= 1'b1;
            out_last_r  <= !found_r;
            kept_r      <= kept_r + CW'(1);
          end
        end
        S_ORDD: begin
          out_valid_r <= 1'b1;
          out_last_r  <= ((sa_r + CW'(1)) == cnt_r);
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              cnt_r <= '0;
              ovf_r <= 1'b0;
            end else if (ord_r) begin
              sa_r <= sa_r + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pidx_r <= sa_r[AW-1:0];
    if (state_r == S_SCAN && pv_r && better) begin
      best_key_r <= rd_key;
      best_ref_r <= rd_ref;
    end
    if (state_r == S_DEC) begin
      cand_key_r <= best_key_r;
      cand_ref_r <= best_ref_r;
      if (have_r) begin
        out_key_r  <= cand_key_r;
        out_ref_r  <= cand_ref_r;
        out_kept_r <= found_r ? '0 : CNT_W'(kept_r + CW'(1));
        out_ovf_r  <= !found_r && ovf_r;
      end
    end
    if (state_r == S_ORDD) begin
      out_key_r  <= rd_key;
      out_ref_r  <= rd_ref;
      out_kept_r <= ((sa_r + CW'(1)) == cnt_r) ? CNT_W'(cnt_r) : '0;
      out_ovf_r  <= ((sa_r + CW'(1)) == cnt_r) && ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key        = out_key_r;
  assign out_ref        = out_ref_r;
  assign out_last       = out_last_r;
  assign out_kept_count = out_kept_r;
  assign out_overflowed = out_ovf_r;

endmodule
